@@ rtl/core/fpss_pkg.sv @@
`default_nettype none

package fpss_pkg;

  // configuration register widths and reset values
  localparam int SPR_W   = 13;
  localparam int RPM_W   = 10;
  localparam int RST_SPR = 64;
  localparam int RST_RPM = 28;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEPS_PER_REV = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_RPM     = 1'b1;
  localparam int CFG_DW = SPR_W;

  // request kinds carried on tuser
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_MOVE = 1'b1;

  // interval arithmetic
  localparam int US_PER_MINUTE = 60000000;
  localparam int ELAPSED_W     = 26;
  localparam int QUO_W         = 26;
  localparam int DVS_W         = SPR_W + RPM_W;

  // result fields
  localparam int COIL_W    = 4;
  localparam int POS_OUT_W = 12;
  localparam int OUT_DW    = 24;

  typedef struct packed {
    logic                 move_rejected;
    logic                 busy_res;
    logic                 stepped;
    logic [POS_OUT_W-1:0] position;
    logic [COIL_W-1:0]    coils;
  } fpss_res_t;

  localparam int RES_W = $bits(fpss_res_t);

  // divider status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } fpss_div_sts_t;

  // full-step coil pattern, bit3 is wire1
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      2'd0:    pat = 4'd10;
      2'd1:    pat = 4'd6;
      2'd2:    pat = 4'd5;
      2'd3:    pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fpss_div.sv @@
`default_nettype none

module fpss_div
  import fpss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVS_W-1:0] divisor,
  output fpss_div_sts_t         sts,
  output logic [QUO_W-1:0]      quot
);

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUO_W - 1);

  logic [QUO_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, q_r[QUO_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
    q_nxt   = {q_r[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= QUO_W'(US_PER_MINUTE);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = q_r;

endmodule

`default_nettype wire

@@ rtl/core/four_phase_stepper_sequencer_top.sv @@
// channel   ports                      payload
// in        in_tvalid/in_tready        tuser: req_type; tdata: move_steps
// out       out_tvalid/out_tready      tdata: coils, position, stepped, busy_res, move_rejected
// cfg       cfg_we/cfg_addr/cfg_wdata  0 steps_per_rev, 1 speed_rpm
//
// one request per cycle while in_tready is high; each result is registered on acceptance
// a config write starts the interval divider: in_tready is low during the write, while the start
// is registered, while the bit-serial divider forms the quotient and while the result loads
// a two-entry output buffer keeps in_tready high while one result waits on out_tready
// reset is synchronous, active low; the reset interval is a constant
`default_nettype none

module four_phase_stepper_sequencer_top
  import fpss_pkg::*;
#(
  parameter int MAX_STEPS_PER_REV = 4096,
  parameter int MOVE_WIDTH        = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // bit 0: req_type
  input  wire logic                                in_tuser,
  // move_steps from bit 0, zero padded to bytes
  input  wire logic [((MOVE_WIDTH + 7) / 8)*8-1:0] in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // coils [3:0], position [15:4], stepped [16], busy_res [17], move_rejected [18]
  output logic [OUT_DW-1:0]                        out_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]               cfg_addr,
  input  wire logic [CFG_DW-1:0]                   cfg_wdata
);

  localparam int POS_W   = $clog2(MAX_STEPS_PER_REV);
  localparam int CW      = (POS_W + 1 > SPR_W) ? POS_W + 1 : SPR_W;
  localparam int RST_EFF = (RST_SPR > MAX_STEPS_PER_REV) ? MAX_STEPS_PER_REV : RST_SPR;
  localparam int RST_INTERVAL = US_PER_MINUTE / (RST_EFF * RST_RPM);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // configuration registers
  logic [SPR_W-1:0] spr_r;
  logic [RPM_W-1:0] rpm_r;
  logic             div_go_r;

  // interval from the current config, and the interval in use
  logic [QUO_W-1:0] cfg_int_r;
  logic [QUO_W-1:0] interval_r, interval_nxt;

  // sequencer state
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [MOVE_WIDTH-1:0] rem_r, rem_nxt;
  logic                  fwd_r, fwd_nxt;
  logic [ELAPSED_W-1:0]  el_r, el_nxt;
  logic [COIL_W-1:0]     coil_r, coil_nxt;

  // output buffer
  fpss_res_t main_r, skid_r, res_nxt;
  logic      main_v_r, skid_v_r;

  fpss_div_sts_t    div_sts;
  logic [QUO_W-1:0] div_quot;
  logic [SPR_W-1:0] eff_spr;
  logic [RPM_W-1:0] eff_rpm;
  logic [DVS_W-1:0] dvs;

  logic                  push, pop;
  logic                  idle;
  logic [QUO_W-1:0]      int_use;
  logic [MOVE_WIDTH-1:0] move, mag;
  logic                  neg;
  logic [ELAPSED_W-1:0]  el_inc;
  logic                  step_go;
  logic                  rejected;
  logic [CW-1:0]         pos_ext, n_ext;

  // clamp the config to its working range, then form the divisor
  always_comb begin
    eff_spr = spr_r;
    if (spr_r == '0) eff_spr = SPR_W'(1);
    else if (32'(spr_r) > 32'(MAX_STEPS_PER_REV)) eff_spr = SPR_W'(MAX_STEPS_PER_REV);
    eff_rpm = (rpm_r == '0) ? RPM_W'(1) : rpm_r;
    dvs     = DVS_W'(eff_spr) * DVS_W'(eff_rpm);
  end

  fpss_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_go_r),
    .divisor (dvs),
    .sts     (div_sts),
    .quot    (div_quot)
  );

  // hold off requests while the output buffer is full or the interval is being rebuilt and loaded
  assign in_tready = !skid_v_r && !div_sts.busy && !div_sts.done && !div_go_r && !cfg_we;
  assign push      = in_tvalid && in_tready;
  assign pop       = main_v_r && out_tready;

  // one request through the sequencer
  always_comb begin
    idle     = (rem_r == '0);
    int_use  = idle ? cfg_int_r : interval_r;
    move     = in_tdata[MOVE_WIDTH-1:0];
    neg      = move[MOVE_WIDTH-1];
    // negating the most negative count gives its magnitude as unsigned
    mag      = neg ? MOVE_WIDTH'(-move) : move;
    el_inc   = (el_r == ELAPSED_MAX) ? el_r : el_r + 1'b1;
    pos_ext  = CW'(pos_r);
    n_ext    = CW'(eff_spr);

    interval_nxt = int_use;
    pos_nxt      = pos_r;
    rem_nxt      = rem_r;
    fwd_nxt      = fwd_r;
    el_nxt       = el_r;
    coil_nxt     = coil_r;
    rejected     = 1'b0;
    step_go      = 1'b0;

    if (in_tuser == REQ_MOVE) begin
      if (!idle) begin
        rejected = 1'b1;
      end else if (mag != '0) begin
        fwd_nxt = !neg;
        rem_nxt = mag;
      end
    end else begin
      el_nxt = el_inc;
      if (!idle && (QUO_W'(el_inc) >= int_use)) begin
        step_go = 1'b1;
        el_nxt  = '0;
        rem_nxt = rem_r - 1'b1;
        if (fwd_r) begin
          pos_nxt = (pos_ext + 1'b1 >= n_ext) ? '0 : POS_W'(pos_ext + 1'b1);
        end else begin
          // reverse from zero or from beyond the wrap count lands on the last step
          pos_nxt = (pos_r == '0 || pos_ext >= n_ext) ? POS_W'(n_ext - 1'b1)
                                                      : pos_r - 1'b1;
        end
        coil_nxt = coil_pattern(pos_nxt[1:0]);
      end
    end

    res_nxt.coils         = coil_nxt;
    res_nxt.position      = POS_OUT_W'(pos_nxt);
    res_nxt.stepped       = step_go;
    res_nxt.busy_res      = (rem_nxt != '0);
    res_nxt.move_rejected = rejected;
  end

  // config registers and divider kick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r    <= SPR_W'(RST_SPR);
      rpm_r    <= RPM_W'(RST_RPM);
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_STEPS_PER_REV: spr_r <= cfg_wdata;
          CFG_SPEED_RPM:     rpm_r <= cfg_wdata[RPM_W-1:0];
          default:           ;
        endcase
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_int_r  <= QUO_W'(RST_INTERVAL);
      interval_r <= QUO_W'(RST_INTERVAL);
      pos_r      <= '0;
      rem_r      <= '0;
      fwd_r      <= 1'b0;
      el_r       <= '0;
      coil_r     <= '0;
    end else begin
      if (div_sts.done) cfg_int_r <= div_quot;
      if (push) begin
        interval_r <= interval_nxt;
        pos_r      <= pos_nxt;
        rem_r      <= rem_nxt;
        fwd_r      <= fwd_nxt;
        el_r       <= el_nxt;
        coil_r     <= coil_nxt;
      end
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_r) skid_v_r <= 1'b0;
        else          main_v_r <= 1'b0;
      end
      if (push) begin
        if (!main_v_r || (pop && !skid_v_r)) main_v_r <= 1'b1;
        else                                 skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) main_r <= skid_r;
    if (push) begin
      if (!main_v_r || (pop && !skid_v_r)) main_r <= res_nxt;
      else                                 skid_r <= res_nxt;
    end
  end

  assign out_tvalid = main_v_r;
  assign out_tdata  = OUT_DW'(main_r);

endmodule

`default_nettype wire

@@ rtl/core/fpss_chk.sv @@
`default_nettype none

module fpss_chk
  import fpss_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic              cfg_we
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a step always leaves a full-step coil pattern
  a_step_coils: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |->
      out_tdata[3:0] == 4'd10 || out_tdata[3:0] == 4'd6 ||
      out_tdata[3:0] == 4'd5  || out_tdata[3:0] == 4'd9)
    else $error("step without a valid coil pattern");

  // a rejected move implies the earlier move is still running
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18] |-> out_tdata[17] && !out_tdata[16])
    else $error("move rejected while idle");

  // after a config write, requests are held off while the divider kick is registered and as the divider starts
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready ##1 !in_tready)
    else $error("request taken during interval update");

endmodule

bind four_phase_stepper_sequencer_top fpss_chk u_fpss_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we)
);

`default_nettype wire
